// ===== rtl/rsmm_pkg.sv =====
// ----------------------------------------------------------------------------
// rsmm_pkg
// Shared types, sizes and codes for the range sum minus minimum tree.
// ----------------------------------------------------------------------------
package rsmm_pkg;

    // Tree sizing
    localparam int CAPACITY     = 1024;
    localparam int ELEMENT_BITS = 48;
    localparam int LEAF_AW      = $clog2(CAPACITY);
    localparam int NODE_AW      = LEAF_AW + 1;
    localparam int NODE_DEPTH   = 2 * CAPACITY;
    localparam int PTR_W        = NODE_AW + 1;
    localparam int TOTAL_BITS   = ELEMENT_BITS + LEAF_AW;

    // Field widths
    localparam int POS_BITS     = 10;
    localparam int DELTA_BITS   = 48;
    localparam int ANSWER_BITS  = 59;
    localparam int COUNT_BITS   = 11;
    localparam int SAT_BITS     = ((ELEMENT_BITS > DELTA_BITS) ? ELEMENT_BITS : DELTA_BITS) + 1;

    // Configuration port
    localparam int PADDR_BITS   = 3;
    localparam int PDATA_BITS   = 32;
    localparam logic REG_ELEMENT_COUNT = 1'b0;
    localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(1024);

    // Element limits
    localparam logic signed [ELEMENT_BITS-1:0] ELEM_MAX = {1'b0, {(ELEMENT_BITS-1){1'b1}}};
    localparam logic signed [ELEMENT_BITS-1:0] ELEM_MIN = {1'b1, {(ELEMENT_BITS-1){1'b0}}};

    // Command codes
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef struct packed {
        logic                         cmd;
        logic [POS_BITS-1:0]          position;
        logic [POS_BITS-1:0]          last_position;
        logic signed [DELTA_BITS-1:0] delta;
    } in_item_t;

    typedef struct packed {
        logic signed [ANSWER_BITS-1:0] answer;
        logic                          status;
    } out_item_t;

    typedef struct packed {
        logic                           en;
        logic [NODE_AW-1:0]             addr;
        logic signed [ELEMENT_BITS-1:0] minimum;
        logic signed [TOTAL_BITS-1:0]   total;
    } node_wr_t;

    typedef struct packed {
        logic               en;
        logic [NODE_AW-1:0] addr;
    } node_rd_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_LEAF,
        ST_ADD_WALK,
        ST_Q_LEFT,
        ST_Q_RIGHT,
        ST_Q_FINISH,
        ST_RESP
    } state_t;

endpackage

// ===== rtl/rsmm_ram.sv =====
// ----------------------------------------------------------------------------
// rsmm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rsmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/rsmm_cfg.sv =====
// ----------------------------------------------------------------------------
// rsmm_cfg
// APB register file holding the element count; clamps it to the capacity.
// ----------------------------------------------------------------------------
module rsmm_cfg import rsmm_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0] prdata,
    output logic                  pready,
    output logic [COUNT_BITS-1:0] active_count
);

    localparam logic [COUNT_BITS-1:0] CAP_COUNT = COUNT_BITS'(CAPACITY);

    logic [COUNT_BITS-1:0] element_count_reg;
    logic [COUNT_BITS-1:0] element_count_next;
    logic                  sel_count;

    assign pready    = 1'b1;
    assign sel_count = (paddr[PADDR_BITS-1:2] == REG_ELEMENT_COUNT);

    always_comb begin
        element_count_next = element_count_reg;
        if (psel && penable && pwrite && pready && sel_count) begin
            element_count_next = pwdata[COUNT_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            element_count_reg <= COUNT_RESET;
        end else begin
            element_count_reg <= element_count_next;
        end
    end

    assign prdata = sel_count ? PDATA_BITS'(element_count_reg) : '0;

    assign active_count = (element_count_reg > CAP_COUNT) ? CAP_COUNT : element_count_reg;

endmodule

// ===== rtl/rsmm_engine.sv =====
// ----------------------------------------------------------------------------
// rsmm_engine
// Sequencer and datapath: clears the node store, walks leaf-to-root for
// adds, walks the range bottom-up for queries, holds the result register.
// ----------------------------------------------------------------------------
module rsmm_engine import rsmm_pkg::*; (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [COUNT_BITS-1:0]          active_count,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  in_item_t                       s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output out_item_t                      m_data,
    output node_wr_t                       node_wr,
    output node_rd_t                       node_rd,
    input  logic signed [ELEMENT_BITS-1:0] rd_minimum,
    input  logic signed [TOTAL_BITS-1:0]   rd_total
);

    localparam logic [NODE_AW-1:0] NODE_ROOT = NODE_AW'(1);
    localparam logic [NODE_AW-1:0] NODE_LAST = {NODE_AW{1'b1}};
    localparam logic [NODE_AW-1:0] NODE_CAP  = NODE_AW'(CAPACITY);
    localparam logic [PTR_W-1:0]   PTR_CAP   = PTR_W'(CAPACITY);
    localparam logic signed [SAT_BITS-1:0] SAT_MAX = SAT_BITS'(ELEM_MAX);
    localparam logic signed [SAT_BITS-1:0] SAT_MIN = SAT_BITS'(ELEM_MIN);

    state_t                         state_reg, state_next;
    logic [NODE_AW-1:0]             clr_addr_reg, clr_addr_next;
    logic [NODE_AW-1:0]             node_reg, node_next;
    logic signed [DELTA_BITS-1:0]   delta_reg, delta_next;
    logic signed [ELEMENT_BITS-1:0] cur_min_reg, cur_min_next;
    logic signed [TOTAL_BITS-1:0]   cur_tot_reg, cur_tot_next;
    logic [PTR_W-1:0]               l_reg, l_next;
    logic [PTR_W-1:0]               r_reg, r_next;
    logic                           pend_reg, pend_next;
    logic signed [TOTAL_BITS-1:0]   sum_reg, sum_next;
    logic signed [ELEMENT_BITS-1:0] mn_reg, mn_next;
    logic signed [ANSWER_BITS-1:0]  ans_reg, ans_next;
    logic                           status_reg, status_next;
    logic                           m_valid_reg, m_valid_next;
    out_item_t                      m_data_reg, m_data_next;

    logic                           is_add;
    logic                           item_bad;
    logic                           out_free;
    logic [NODE_AW-1:0]             parent;
    logic [PTR_W-1:0]               r_dec;
    logic signed [ELEMENT_BITS-1:0] leaf_elem;
    logic signed [SAT_BITS-1:0]     leaf_sum;
    logic signed [ELEMENT_BITS-1:0] leaf_val;
    logic signed [ELEMENT_BITS-1:0] join_min;
    logic signed [TOTAL_BITS-1:0]   join_tot;

    assign is_add   = (s_data.cmd == CMD_ADD);
    assign item_bad = is_add ?
        (COUNT_BITS'(s_data.position) >= active_count) :
        ((s_data.position > s_data.last_position) ||
         (COUNT_BITS'(s_data.last_position) >= active_count));
    assign out_free = !m_valid_reg || m_ready;
    assign parent   = node_reg >> 1;
    assign r_dec    = r_reg - PTR_W'(1);

    // Leaf update saturates at the element range
    assign leaf_elem = rd_total[ELEMENT_BITS-1:0];
    assign leaf_sum  = SAT_BITS'(leaf_elem) + SAT_BITS'(delta_reg);
    always_comb begin
        priority if (leaf_sum > SAT_MAX) begin
            leaf_val = ELEM_MAX;
        end else if (leaf_sum < SAT_MIN) begin
            leaf_val = ELEM_MIN;
        end else begin
            leaf_val = leaf_sum[ELEMENT_BITS-1:0];
        end
    end

    // Combine the node just written with its sibling from memory
    assign join_min = (rd_minimum < cur_min_reg) ? rd_minimum : cur_min_reg;
    assign join_tot = cur_tot_reg + rd_total;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == NODE_LAST) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    priority if (item_bad) state_next = ST_RESP;
                    else if (is_add)        state_next = ST_ADD_LEAF;
                    else                    state_next = ST_Q_LEFT;
                end
            end
            ST_ADD_LEAF: state_next = ST_ADD_WALK;
            ST_ADD_WALK: begin
                if (parent == NODE_ROOT) state_next = ST_RESP;
            end
            ST_Q_LEFT: begin
                state_next = (l_reg >= r_reg) ? ST_Q_FINISH : ST_Q_RIGHT;
            end
            ST_Q_RIGHT:  state_next = ST_Q_LEFT;
            ST_Q_FINISH: state_next = ST_RESP;
            ST_RESP: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb begin
        clr_addr_next = clr_addr_reg;
        node_next     = node_reg;
        delta_next    = delta_reg;
        cur_min_next  = cur_min_reg;
        cur_tot_next  = cur_tot_reg;
        l_next        = l_reg;
        r_next        = r_reg;
        pend_next     = 1'b0;
        sum_next      = sum_reg;
        mn_next       = mn_reg;
        ans_next      = ans_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        node_wr       = '0;
        node_rd       = '0;

        // Fold in the node read on the previous cycle
        if (pend_reg) begin
            sum_next = sum_reg + rd_total;
            mn_next  = (rd_minimum < mn_reg) ? rd_minimum : mn_reg;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                node_wr.en    = 1'b1;
                node_wr.addr  = clr_addr_reg;
                clr_addr_next = clr_addr_reg + NODE_AW'(1);
            end
            ST_IDLE: begin
                if (s_valid) begin
                    delta_next  = s_data.delta;
                    node_next   = NODE_CAP + NODE_AW'(s_data.position);
                    l_next      = PTR_CAP + PTR_W'(s_data.position);
                    r_next      = PTR_CAP + PTR_W'(s_data.last_position) + PTR_W'(1);
                    sum_next    = '0;
                    mn_next     = ELEM_MAX;
                    ans_next    = '0;
                    status_next = item_bad ? STATUS_ERR : STATUS_OK;
                    if (!item_bad && is_add) begin
                        node_rd.en   = 1'b1;
                        node_rd.addr = NODE_CAP + NODE_AW'(s_data.position);
                    end
                end
            end
            ST_ADD_LEAF: begin
                node_wr.en      = 1'b1;
                node_wr.addr    = node_reg;
                node_wr.minimum = leaf_val;
                node_wr.total   = TOTAL_BITS'(leaf_val);
                cur_min_next    = leaf_val;
                cur_tot_next    = TOTAL_BITS'(leaf_val);
                node_rd.en      = 1'b1;
                node_rd.addr    = node_reg ^ NODE_AW'(1);
            end
            ST_ADD_WALK: begin
                node_wr.en      = 1'b1;
                node_wr.addr    = parent;
                node_wr.minimum = join_min;
                node_wr.total   = join_tot;
                cur_min_next    = join_min;
                cur_tot_next    = join_tot;
                node_next       = parent;
                if (parent != NODE_ROOT) begin
                    node_rd.en   = 1'b1;
                    node_rd.addr = parent ^ NODE_AW'(1);
                end
            end
            ST_Q_LEFT: begin
                if ((l_reg < r_reg) && l_reg[0]) begin
                    node_rd.en   = 1'b1;
                    node_rd.addr = l_reg[NODE_AW-1:0];
                    pend_next    = 1'b1;
                    l_next       = l_reg + PTR_W'(1);
                end
            end
            ST_Q_RIGHT: begin
                l_next = l_reg >> 1;
                if (r_reg[0]) begin
                    node_rd.en   = 1'b1;
                    node_rd.addr = r_dec[NODE_AW-1:0];
                    pend_next    = 1'b1;
                    r_next       = r_dec >> 1;
                end else begin
                    r_next = r_reg >> 1;
                end
            end
            ST_Q_FINISH: begin
                ans_next = ANSWER_BITS'(sum_reg) - ANSWER_BITS'(mn_reg);
            end
            ST_RESP: begin
                if (out_free) begin
                    m_valid_next       = 1'b1;
                    m_data_next.answer = ans_reg;
                    m_data_next.status = status_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            pend_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            pend_reg     <= pend_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        node_reg    <= node_next;
        delta_reg   <= delta_next;
        cur_min_reg <= cur_min_next;
        cur_tot_reg <= cur_tot_next;
        l_reg       <= l_next;
        r_reg       <= r_next;
        sum_reg     <= sum_next;
        mn_reg      <= mn_next;
        ans_reg     <= ans_next;
        status_reg  <= status_next;
        m_data_reg  <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/range_sum_minus_min_tree_core.sv =====
// ----------------------------------------------------------------------------
// range_sum_minus_min_tree_core
// Sequence, accept to result valid: an add reads and writes the leaf, then a
//   sibling read and parent write per level; a query passes ST_Q_LEFT and ST_Q_RIGHT per level.
// Throughput: one transaction in work; the next is accepted only after the
//   result of the last one loads into the result register.
// Reset: synchronous, active low; a clearing pass zeroes the node store,
//   and no transaction is accepted until it ends.
// ----------------------------------------------------------------------------
module range_sum_minus_min_tree_core import rsmm_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0] prdata,
    output logic                  pready,
    // Item channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    // Result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data
);

    // The tree is stored bottom-up: leaf k at node CAPACITY+k, node p covers
    // nodes 2p and 2p+1. Minimum and total of each node live in two RAMs
    // that share read and write addresses, so one access fetches a node.

    logic [COUNT_BITS-1:0]          active_count;
    node_wr_t                       node_wr;
    node_rd_t                       node_rd;
    logic [ELEMENT_BITS-1:0]        min_rd_data;
    logic [TOTAL_BITS-1:0]          tot_rd_data;
    logic signed [ELEMENT_BITS-1:0] rd_minimum;
    logic signed [TOTAL_BITS-1:0]   rd_total;

    // Register file: element count, clamped to the capacity
    rsmm_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .active_count (active_count)
    );

    // Sequencer: clears the store, then walks the tree for each transaction.
    // Writes and reads in one cycle never hit the same node, and a new
    // transaction reads only after the last write of the previous one.
    rsmm_engine u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .active_count (active_count),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .node_wr      (node_wr),
        .node_rd      (node_rd),
        .rd_minimum   (rd_minimum),
        .rd_total     (rd_total)
    );

    // Node minimum store
    rsmm_ram #(
        .WIDTH (ELEMENT_BITS),
        .DEPTH (NODE_DEPTH)
    ) u_min_ram (
        .aclk    (aclk),
        .wr_en   (node_wr.en),
        .wr_addr (node_wr.addr),
        .wr_data (node_wr.minimum),
        .rd_en   (node_rd.en),
        .rd_addr (node_rd.addr),
        .rd_data (min_rd_data)
    );

    // Node total store
    rsmm_ram #(
        .WIDTH (TOTAL_BITS),
        .DEPTH (NODE_DEPTH)
    ) u_tot_ram (
        .aclk    (aclk),
        .wr_en   (node_wr.en),
        .wr_addr (node_wr.addr),
        .wr_data (node_wr.total),
        .rd_en   (node_rd.en),
        .rd_addr (node_rd.addr),
        .rd_data (tot_rd_data)
    );

    // Reinterpret the raw RAM words as signed values
    assign rd_minimum = min_rd_data;
    assign rd_total   = tot_rd_data;

endmodule

// ===== rtl/rsmm_checker.sv =====
// ----------------------------------------------------------------------------
// rsmm_checker
// Port-level checks on the tree core, bound to the top level.
// ----------------------------------------------------------------------------
module rsmm_checker import rsmm_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input out_item_t             m_data
);

    // Hold a stalled result
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // An error result carries a zero answer
    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == STATUS_ERR) |-> (m_data.answer == '0))
        else $error("error result with nonzero answer");

    // Reset starts the clearing pass, which blocks the item channel
    a_clear_blocks: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("item channel open right after reset");

    // One transaction in work at a time
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transaction accepted back to back");

endmodule

bind range_sum_minus_min_tree_core rsmm_checker u_rsmm_checker (.*);

// ===== bench/tb_range_sum_minus_min_tree_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_range_sum_minus_min_tree_core
// Self-checking bench for the range sum minus minimum tree. A mirror of the
// element array predicts every result from the accepted items. Results are
// checked in order against that prediction. Directed corner items come first,
// then random phases under different element counts, with random idle cycles
// and back-pressure on both channels.
// ----------------------------------------------------------------------------
module tb_range_sum_minus_min_tree_core import rsmm_pkg::*; ();

    // Mirror of the element array. Sums and minima are computed straight
    // from the elements, which is what every tree node holds.
    class tree_mirror;
        longint    elem [CAPACITY];
        bit [COUNT_BITS-1:0] count;
        out_item_t owed_results [$];
        int        faults;

        function new();
            foreach (elem[k]) elem[k] = 0;
            count  = COUNT_RESET;
            faults = 0;
        endfunction

        function void set_count(logic [COUNT_BITS-1:0] value);
            count = value;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        // Predict the result of one accepted transaction.
        function void note_item(in_item_t it);
            out_item_t r;
            int        cnt;
            longint    v;
            longint    acc;
            longint    low;
            longint    ans_hi;
            longint    ans_lo;
            ans_hi   = (longint'(1) <<< (ANSWER_BITS - 1)) - 1;
            ans_lo   = -(longint'(1) <<< (ANSWER_BITS - 1));
            r        = '0;
            r.status = STATUS_OK;
            cnt      = (int'(count) > CAPACITY) ? CAPACITY : int'(count);
            if (it.cmd == CMD_ADD) begin
                if (int'(it.position) >= cnt) begin
                    r.status = STATUS_ERR;
                end else begin
                    v = elem[it.position] + longint'($signed(it.delta));
                    if (v > longint'(ELEM_MAX)) v = longint'(ELEM_MAX);
                    if (v < longint'(ELEM_MIN)) v = longint'(ELEM_MIN);
                    elem[it.position] = v;
                end
            end else begin
                if (it.position > it.last_position || int'(it.last_position) >= cnt) begin
                    r.status = STATUS_ERR;
                end else begin
                    acc = 0;
                    low = elem[it.position];
                    for (int k = it.position; k <= int'(it.last_position); k++) begin
                        acc += elem[k];
                        if (elem[k] < low) low = elem[k];
                    end
                    v = acc - low;
                    if (v > ans_hi) v = ans_hi;
                    if (v < ans_lo) v = ans_lo;
                    r.answer = v[ANSWER_BITS-1:0];
                end
            end
            owed_results = {owed_results, r};
        endfunction

        // Compare one accepted result with the oldest prediction.
        function void check_result(out_item_t got);
            out_item_t want;
            if (owed_results.size() == 0) begin
                $error("result with no prediction waiting: answer %0d status %0d",
                       $signed(got.answer), got.status);
                faults++;
                return;
            end
            want = owed_results.pop_front();
            if (got.answer !== want.answer) begin
                $error("answer mismatch: expected %0d, actual %0d",
                       $signed(want.answer), $signed(got.answer));
                faults++;
            end
            if (got.status !== want.status) begin
                $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
                faults++;
            end
        endfunction
    endclass

    // Clock, reset and block inputs; all start at known values.
    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [PADDR_BITS-1:0] paddr   = '0;
    logic [PDATA_BITS-1:0] pwdata  = '0;
    logic [PDATA_BITS-1:0] prdata;
    logic                  pready;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;

    tree_mirror  mirror;
    bit          no_idle = 1'b0;   // set for phases that run without gaps
    int unsigned rx_hold = 0;

    range_sum_minus_min_tree_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 4);
        return $urandom_range(12, 40);
    endfunction

    function automatic in_item_t mk_item(logic cmd, int unsigned pos, int unsigned last,
                                         logic signed [DELTA_BITS-1:0] delta);
        in_item_t it;
        it.cmd           = cmd;
        it.position      = POS_BITS'(pos);
        it.last_position = POS_BITS'(last);
        it.delta         = delta;
        return it;
    endfunction

    // Build one random transaction for the given active count. Most are well
    // formed; the rest land outside the range or reverse the query bounds.
    function automatic in_item_t random_item(int unsigned cnt);
        in_item_t    it;
        logic [63:0] w;
        int unsigned r;
        int unsigned a;
        int unsigned b;
        w  = {$urandom, $urandom};
        it = mk_item(CMD_ADD, $urandom_range(0, CAPACITY - 1), $urandom_range(0, CAPACITY - 1),
                     w[DELTA_BITS-1:0]);
        // Pick the delta: small, extreme, or full width.
        r = $urandom_range(0, 99);
        if (r < 50) begin
            it.delta = DELTA_BITS'($signed($urandom_range(0, 2000000)) - 1000000);
        end else if (r < 65) begin
            case ($urandom_range(0, 3))
                0: it.delta = ELEM_MAX;
                1: it.delta = ELEM_MIN;
                2: it.delta = '0;
                default: it.delta = '1;
            endcase
        end
        it.cmd = ($urandom_range(0, 99) < 45) ? CMD_ADD : CMD_QUERY;
        r = $urandom_range(0, 99);
        if (cnt == 0 || r >= 85) begin
            // Noise: leave the random positions, or aim past the count.
            if (cnt != 0 && cnt < CAPACITY && r >= 93)
                it.position = POS_BITS'($urandom_range(cnt, CAPACITY - 1));
            return it;
        end
        a = $urandom_range(0, cnt - 1);
        if (it.cmd == CMD_ADD) begin
            it.position = POS_BITS'(a);
        end else begin
            if ($urandom_range(0, 99) < 35) begin
                b = a + $urandom_range(0, 7);
                if (b > cnt - 1) b = cnt - 1;
            end else begin
                b = $urandom_range(a, cnt - 1);
            end
            // Reverse the bounds now and then for an empty range.
            if (a != b && $urandom_range(0, 99) < 8) begin
                it.position      = POS_BITS'(b);
                it.last_position = POS_BITS'(a);
            end else begin
                it.position      = POS_BITS'(a);
                it.last_position = POS_BITS'(b);
            end
        end
        return it;
    endfunction

    // Present one transaction and hold it until accepted. Valid stays high
    // between back-to-back items; it drops only ahead of a gap.
    task automatic send_item(in_item_t it);
        int unsigned gap;
        gap = no_idle ? 0 : gap_len();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        mirror.note_item(it);
    endtask

    // Drop valid after the last item of a phase.
    task automatic stop_items();
        s_valid <= 1'b0;
    endtask

    // Wait until every predicted result has come back, then let the block settle.
    task automatic drain();
        while (mirror.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write the element count through the configuration port: setup, then
    // access until pready.
    task automatic write_count(logic [PDATA_BITS-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_BITS'(4 * int'(REG_ELEMENT_COUNT));
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        mirror.set_count(value[COUNT_BITS-1:0]);
    endtask

    // Result side back-pressure: alternate ready runs and stalls of random length.
    always @(posedge aclk) begin
        if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
        end else if (no_idle) begin
            m_ready <= 1'b1;
        end else if (m_ready) begin
            m_ready <= 1'b0;
            rx_hold <= gap_len();
        end else begin
            m_ready <= 1'b1;
            rx_hold <= $urandom_range(0, 15);
        end
    end

    // Check every result transaction at the edge it is accepted.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) mirror.check_result(m_data);
    end

    // Hard limit on run time, well beyond the slowest correct run.
    initial begin
        #10_000_000;
        $display("tb_range_sum_minus_min_tree_core failed");
        $finish;
    end

    initial begin
        int unsigned plan [11];
        int unsigned cnt;
        int unsigned eff;
        int unsigned n;
        logic [PDATA_BITS-1:0] word;
        plan   = '{16, 1024, 2, 1023, 2047, 1, 300, 0, 1025, 64, 1024};
        mirror = new();

        // Hold reset, then release it for good.
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset count: full-width ranges, saturation of
        // single elements at both limits, single-element and empty ranges.
        send_item(mk_item(CMD_QUERY, 0, CAPACITY - 1, '0));
        send_item(mk_item(CMD_ADD, 0, 0, ELEM_MAX));
        send_item(mk_item(CMD_ADD, 0, CAPACITY - 1, 48'sd1));
        send_item(mk_item(CMD_ADD, CAPACITY - 1, 0, ELEM_MIN));
        send_item(mk_item(CMD_ADD, CAPACITY - 1, 0, -48'sd1));
        send_item(mk_item(CMD_ADD, 512, 7, -48'sd5));
        send_item(mk_item(CMD_QUERY, 0, CAPACITY - 1, ELEM_MAX));
        send_item(mk_item(CMD_QUERY, CAPACITY - 1, CAPACITY - 1, '0));
        send_item(mk_item(CMD_QUERY, 0, 0, '1));
        send_item(mk_item(CMD_QUERY, 5, 4, '0));
        send_item(mk_item(CMD_QUERY, CAPACITY - 1, 0, '0));
        send_item(mk_item(CMD_ADD, 0, 0, ELEM_MIN));
        send_item(mk_item(CMD_QUERY, 0, 1, '0));
        stop_items();
        drain();

        // Count of zero: every index is out of range.
        write_count(32'd0);
        send_item(mk_item(CMD_ADD, 0, 0, 48'sd9));
        send_item(mk_item(CMD_QUERY, 0, 0, '0));
        stop_items();
        drain();

        // Count beyond capacity acts as capacity; the store is kept.
        write_count(32'd2047);
        send_item(mk_item(CMD_QUERY, 0, CAPACITY - 1, '0));
        send_item(mk_item(CMD_ADD, CAPACITY - 1, 0, 48'sd7));
        stop_items();
        drain();

        // Single element in use.
        write_count(32'd1);
        send_item(mk_item(CMD_ADD, 0, 0, 48'sd3));
        send_item(mk_item(CMD_ADD, 1, 0, 48'sd3));
        send_item(mk_item(CMD_QUERY, 0, 0, '0));
        send_item(mk_item(CMD_QUERY, 0, 1, '0));
        send_item(mk_item(CMD_QUERY, 1, 1, '0));
        stop_items();
        drain();

        // Random phases, one per count setting. Upper data bits of the
        // register write are random and must be dropped by the block.
        foreach (plan[p]) begin
            cnt = (p == 6) ? $urandom_range(2, CAPACITY - 2) : plan[p];
            word = $urandom;
            word[COUNT_BITS-1:0] = COUNT_BITS'(cnt);
            write_count(word);
            eff     = (cnt > CAPACITY) ? CAPACITY : cnt;
            no_idle = ($urandom_range(0, 3) == 0);
            n       = (cnt == 0) ? 20 : 150;
            repeat (n) send_item(random_item(eff));
            stop_items();
            drain();
            no_idle = 1'b0;
        end

        // Allow any straggling result to show up before the verdict.
        repeat (40) @(posedge aclk);
        if (mirror.pending() != 0) begin
            $error("%0d predicted results never arrived", mirror.pending());
            mirror.faults++;
        end
        if (mirror.faults == 0) begin
            $display("tb_range_sum_minus_min_tree_core passed");
        end else begin
            $display("tb_range_sum_minus_min_tree_core failed");
        end
        $finish;
    end

endmodule
